### hw/rtl/dil_pkg.sv
// ----------------------------------------------------------------------------
// dil_pkg
// shared types and constants of the morphological dilation core
// ----------------------------------------------------------------------------
`default_nettype none

package dil_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 4096;
    localparam int MAX_SE_SIZE_DEF = 7;

    localparam int PIX_W          = 8;
    localparam int WORD_W         = 4 * PIX_W;
    localparam int COLOR_W        = 3 * PIX_W;
    localparam int MASK_W         = 49;
    localparam int MASK_STRIDE    = 7;
    localparam int SE_W           = 3;
    localparam int STORE_ROW_BITS = 3;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SE_MASK        = 3'd0,
        CFG_SE_WIDTH       = 3'd1,
        CFG_SE_HEIGHT      = 3'd2,
        CFG_SE_HALF_WIDTH  = 3'd3,
        CFG_SE_HALF_HEIGHT = 3'd4,
        CFG_IMAGE_WIDTH    = 3'd5,
        CFG_IMAGE_HEIGHT   = 3'd6,
        CFG_PIXEL_FORMAT   = 3'd7
    } cfg_idx_t;

    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGBA = 2'd2;

    // window read travelling down the cell row
    typedef struct packed {
        logic               valid;
        logic [SE_W-1:0]    tag;
        logic               take;
        logic [COLOR_W-1:0] pix;
    } tok_t;

endpackage

`default_nettype wire

### hw/rtl/morphological_dilation_core.sv
// ----------------------------------------------------------------------------
// morphological_dilation_core
// streaming grayscale / color dilation with a configurable mask up to 7x7
// ----------------------------------------------------------------------------
// an item that releases no result goes through the check state and back to idle;
// one that releases a result reads every window position through the single line
// store read port, then the reads run through the cell row; a finished result
// waits in the output register while the next item is taken. reset clears the
// input and output position counters, config and handshake state; the line
// store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module morphological_dilation_core #(
    parameter int MAX_WIDTH   = dil_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = dil_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SE_SIZE = dil_pkg::MAX_SE_SIZE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [dil_pkg::WORD_W-1:0]    s_tdata,   // chan_a, chan_b, chan_c, alpha_in
    input  wire logic                          s_tuser,   // req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [dil_pkg::WORD_W-1:0]    m_tdata,   // out_a, out_b, out_c, out_alpha
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [dil_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dil_pkg::MASK_W-1:0]    cfg_data
);
    import dil_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CNW    = $clog2(MAX_WIDTH + 1);
    localparam int RNW    = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = STORE_ROW_BITS + CW;
    localparam int XS     = CNW + 2;
    localparam int YS     = RNW + 2;
    localparam int FLUSH  = MAX_SE_SIZE + 1;
    localparam int FW     = $clog2(FLUSH);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_ALPHA  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_FLUSH  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [MASK_W-1:0] se_mask_reg;
    logic [SE_W-1:0]   se_width_reg, se_height_reg, se_half_width_reg, se_half_height_reg;
    logic [10:0]       image_width_reg;
    logic [12:0]       image_height_reg;
    logic [1:0]        pixel_format_reg;

    logic [CNW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RNW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [RNW-1:0] oy_reg, oy_next;
    logic [CNW-1:0] ox_reg, ox_next;
    logic [SE_W-1:0] ky_reg, ky_next, kx_reg, kx_next;
    logic [FW-1:0]   fcnt_reg, fcnt_next;
    logic            alpha_pend_reg;
    logic [PIX_W-1:0] alpha_reg;
    tok_t            meta_reg;

    logic               m_tvalid_reg;
    logic [WORD_W-1:0]  m_tdata_reg;
    logic               m_tlast_reg;

    logic [CNW-1:0] w_v;
    logic [RNW-1:0] h_v;
    logic [SE_W-1:0] kw_v, kh_v, hw_v, hh_v;
    logic            in_acc, in_done, store_en, ready, clear, load, last;
    logic [RNW-1:0]  oy_c, nr_c, cy_c;
    logic [CNW-1:0]  ox_c, nc_c, cx_c, wcol;
    logic [RNW:0]    nr_w;
    logic [CNW:0]    nc_w;
    logic signed [4:0] right_s, down_s;
    logic signed [YS-1:0] ry_s;
    logic signed [XS-1:0] rx_s;
    logic [RNW-1:0]  ry;
    logic [CNW-1:0]  rx;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [5:0]        bit_idx;
    logic [COLOR_W-1:0] mx;

    tok_t               chain [MAX_SE_SIZE+1];
    logic [COLOR_W-1:0] accs  [MAX_SE_SIZE];

    // effective sizes
    always_comb begin
        w_v  = (image_width_reg == '0) ? CNW'(1) :
               (image_width_reg > MAX_WIDTH) ? CNW'(MAX_WIDTH) : CNW'(image_width_reg);
        h_v  = (image_height_reg == '0) ? RNW'(1) :
               (image_height_reg > MAX_HEIGHT) ? RNW'(MAX_HEIGHT) : RNW'(image_height_reg);
        kw_v = (se_width_reg > MAX_SE_SIZE) ? SE_W'(MAX_SE_SIZE) : se_width_reg;
        kh_v = (se_height_reg > MAX_SE_SIZE) ? SE_W'(MAX_SE_SIZE) : se_height_reg;
        hw_v = (se_half_width_reg > MAX_SE_SIZE - 1) ? SE_W'(MAX_SE_SIZE - 1)
                                                     : se_half_width_reg;
        hh_v = (se_half_height_reg > MAX_SE_SIZE - 1) ? SE_W'(MAX_SE_SIZE - 1)
                                                      : se_half_height_reg;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign in_done   = (in_row_reg >= h_v);
    assign store_en  = in_acc && !s_tuser && !in_done;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            se_mask_reg        <= MASK_W'(115591);
            se_width_reg       <= SE_W'(3);
            se_height_reg      <= SE_W'(3);
            se_half_width_reg  <= SE_W'(1);
            se_half_height_reg <= SE_W'(1);
            image_width_reg    <= 11'd640;
            image_height_reg   <= 13'd480;
            pixel_format_reg   <= FMT_GRAY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SE_MASK:        se_mask_reg        <= cfg_data;
                CFG_SE_WIDTH:       se_width_reg       <= cfg_data[SE_W-1:0];
                CFG_SE_HEIGHT:      se_height_reg      <= cfg_data[SE_W-1:0];
                CFG_SE_HALF_WIDTH:  se_half_width_reg  <= cfg_data[SE_W-1:0];
                CFG_SE_HALF_HEIGHT: se_half_height_reg <= cfg_data[SE_W-1:0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[10:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[12:0];
                CFG_PIXEL_FORMAT:   pixel_format_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // readiness of the next pending result
    always_comb begin
        right_s = $signed(5'(kw_v)) - 5'sd1 - $signed(5'(hw_v));
        down_s  = $signed(5'(kh_v)) - 5'sd1 - $signed(5'(hh_v));
        if (right_s < 0) right_s = '0;
        if (down_s < 0)  down_s  = '0;
        oy_c = (out_row_reg < h_v) ? out_row_reg : h_v;
        ox_c = (out_col_reg < w_v) ? out_col_reg : w_v;
        nr_w = {1'b0, oy_c} + (RNW+1)'(down_s[3:0]);
        nc_w = {1'b0, ox_c} + (CNW+1)'(right_s[3:0]);
        nr_c = (nr_w > {1'b0, h_v - RNW'(1)}) ? h_v - RNW'(1) : nr_w[RNW-1:0];
        nc_c = (nc_w > {1'b0, w_v - CNW'(1)}) ? w_v - CNW'(1) : nc_w[CNW-1:0];
        ready = in_done || (in_row_reg > nr_c) || ((in_row_reg == nr_c) && (in_col_reg > nc_c));
        cy_c = (oy_reg > h_v - RNW'(1)) ? h_v - RNW'(1) : oy_reg;
        cx_c = (ox_reg > w_v - CNW'(1)) ? w_v - CNW'(1) : ox_reg;
    end

    // window read address
    always_comb begin
        ry_s = $signed(YS'(oy_reg)) + $signed(YS'(ky_reg)) - $signed(YS'(hh_v));
        rx_s = $signed(XS'(ox_reg)) + $signed(XS'(kx_reg)) - $signed(XS'(hw_v));
        if (ry_s < 0) begin
            ry = '0;
        end else if (ry_s > $signed(YS'(h_v - RNW'(1)))) begin
            ry = h_v - RNW'(1);
        end else begin
            ry = ry_s[RNW-1:0];
        end
        if (rx_s < 0) begin
            rx = '0;
        end else if (rx_s > $signed(XS'(w_v - CNW'(1)))) begin
            rx = w_v - CNW'(1);
        end else begin
            rx = rx_s[CNW-1:0];
        end
        if (state_reg == ST_ALPHA) begin
            rd_addr = {cy_c[STORE_ROW_BITS-1:0], cx_c[CW-1:0]};
        end else begin
            rd_addr = {ry[STORE_ROW_BITS-1:0], rx[CW-1:0]};
        end
        wcol    = (in_col_reg >= MAX_WIDTH) ? CNW'(MAX_WIDTH - 1) : in_col_reg;
        wr_addr = {in_row_reg[STORE_ROW_BITS-1:0], wcol[CW-1:0]};
        bit_idx = 6'(ky_reg) * 6'(MASK_STRIDE) + 6'(kx_reg);
    end

    dil_line_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign chain[0] = '{valid: meta_reg.valid, tag: meta_reg.tag, take: meta_reg.take,
                        pix: rd_data[COLOR_W-1:0]};

    for (genvar i = 0; i < MAX_SE_SIZE; i++) begin : g_cell
        dil_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .clear   (clear),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .acc     (accs[i])
        );
    end

    always_comb begin
        mx = '0;
        for (int i = 0; i < MAX_SE_SIZE; i++) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (accs[i][ch*PIX_W +: PIX_W] > mx[ch*PIX_W +: PIX_W]) begin
                    mx[ch*PIX_W +: PIX_W] = accs[i][ch*PIX_W +: PIX_W];
                end
            end
        end
    end

    assign load = (state_reg == ST_RESULT) && (!m_tvalid_reg || m_tready);
    assign last = (out_row_reg >= h_v - RNW'(1)) && (out_col_reg >= w_v - CNW'(1));
    assign clear = (state_reg == ST_CHECK);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        oy_next      = oy_reg;
        ox_next      = ox_reg;
        ky_next      = ky_reg;
        kx_next      = kx_reg;
        fcnt_next    = fcnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_CHECK;
                    if (store_en) begin
                        if ({1'b0, in_col_reg} + (CNW+1)'(1) >= {1'b0, w_v}) begin
                            in_col_next = '0;
                            in_row_next = in_row_reg + RNW'(1);
                        end else begin
                            in_col_next = in_col_reg + CNW'(1);
                        end
                    end
                end
            end
            ST_CHECK: begin
                oy_next = oy_c;
                ox_next = ox_c;
                ky_next = '0;
                kx_next = '0;
                state_next = ready ? ST_ALPHA : ST_IDLE;
            end
            ST_ALPHA: begin
                fcnt_next  = '0;
                state_next = (kw_v == '0 || kh_v == '0) ? ST_FLUSH : ST_READ;
            end
            ST_READ: begin
                if (kx_reg >= kw_v - SE_W'(1)) begin
                    kx_next = '0;
                    ky_next = ky_reg + SE_W'(1);
                    if (ky_reg >= kh_v - SE_W'(1)) begin
                        state_next = ST_FLUSH;
                    end
                end else begin
                    kx_next = kx_reg + SE_W'(1);
                end
            end
            ST_FLUSH: begin
                fcnt_next = fcnt_reg + FW'(1);
                if (fcnt_reg == FW'(FLUSH - 1)) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (load) begin
                    state_next = ST_IDLE;
                    if (last) begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                    end else if ({1'b0, out_col_reg} + (CNW+1)'(1) >= {1'b0, w_v}) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + RNW'(1);
                    end else begin
                        out_col_next = out_col_reg + CNW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            meta_reg.valid <= 1'b0;
            alpha_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            meta_reg.valid <= (state_reg == ST_READ);
            alpha_pend_reg <= (state_reg == ST_ALPHA);
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        meta_reg.tag  <= kx_reg;
        meta_reg.take <= se_mask_reg[bit_idx];
        meta_reg.pix  <= '0;
    end

    always_ff @(posedge aclk) begin
        oy_reg        <= oy_next;
        ox_reg        <= ox_next;
        ky_reg        <= ky_next;
        kx_reg        <= kx_next;
        fcnt_reg      <= fcnt_next;
        if (alpha_pend_reg) begin
            alpha_reg <= rd_data[WORD_W-1 -: PIX_W];
        end
        if (load) begin
            m_tdata_reg[PIX_W-1:0] <= mx[PIX_W-1:0];
            m_tdata_reg[COLOR_W-1:PIX_W] <= (pixel_format_reg == FMT_GRAY) ? '0
                                            : mx[COLOR_W-1:PIX_W];
            m_tdata_reg[WORD_W-1:COLOR_W] <= (pixel_format_reg == FMT_RGBA) ? alpha_reg
                                             : '0;
            m_tlast_reg <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // the cell row is empty before a result is taken from it
    a_chain_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT) |-> !chain[MAX_SE_SIZE].valid)
        else $error("cell row still busy at result");

    // a waiting result is never overwritten
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && m_tvalid_reg && !m_tready) |=> state_reg == ST_RESULT)
        else $error("result register overwritten");

    // the final result of a frame restarts the input and output position counters
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && last) |=> (in_row_reg == '0 && out_row_reg == '0 && out_col_reg == '0))
        else $error("frame counters not cleared");

endmodule

`default_nettype wire

### hw/rtl/dil_line_store.sv
// ----------------------------------------------------------------------------
// dil_line_store
// row buffer memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dil_line_store #(
    parameter int ADDR_W = 13
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [dil_pkg::WORD_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [dil_pkg::WORD_W-1:0] rd_data
);
    import dil_pkg::*;

    logic [WORD_W-1:0] mem [2**ADDR_W];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/dil_cell.sv
// ----------------------------------------------------------------------------
// dil_cell
// one mask column: keeps the running maximum of its column, passes reads on
// ----------------------------------------------------------------------------
`default_nettype none

module dil_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        clear,
    input  wire dil_pkg::tok_t               tok_in,
    output dil_pkg::tok_t                    tok_out,
    output logic      [dil_pkg::COLOR_W-1:0] acc
);
    import dil_pkg::*;

    tok_t               tok_reg;
    logic [COLOR_W-1:0] acc_reg;
    logic [COLOR_W-1:0] acc_next;
    logic               hit;

    assign hit = tok_in.valid && tok_in.take && (tok_in.tag == SE_W'(CELL_IDX));

    always_comb begin
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (hit) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (tok_in.pix[ch*PIX_W +: PIX_W] > acc_reg[ch*PIX_W +: PIX_W]) begin
                    acc_next[ch*PIX_W +: PIX_W] = tok_in.pix[ch*PIX_W +: PIX_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_in.valid;
        end
        tok_reg.tag  <= tok_in.tag;
        tok_reg.take <= tok_in.take;
        tok_reg.pix  <= tok_in.pix;
        acc_reg      <= acc_next;
    end

    assign tok_out = tok_reg;
    assign acc     = acc_reg;

endmodule

`default_nettype wire
